// File: src/assert_macros.svh
// assertion macros for the palette indexer, used by rpi_tail
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RPI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RPI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/rpi_pkg.sv
`timescale 1ns / 1ps
// shared constants, beat type and table-size helpers for the palette indexer
// no dependencies
package rpi_pkg;

   localparam int PaletteDepth = 256;
   localparam int ColorW       = 8;
   localparam int IndexW       = 8;
   localparam int CountW       = 9;
   localparam int CodeW        = 4;
   localparam int RgbW         = 3 * ColorW;
   localparam logic [CodeW-1:0] MinCode = CodeW'(2);

   typedef logic [RgbW-1:0]   rgb_type;
   typedef logic [IndexW-1:0] index_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [CodeW-1:0]  code_type;

   // one pixel traveling down the cell row with its search state
   typedef struct packed {
      logic      valid;
      rgb_type   rgb;
      logic      last_pixel;
      logic      found;
      index_type pixel_index;
      count_type color_count;
   } beat_type;

   // number of bits needed to hold a 9-bit value
   function automatic code_type bit_len(input count_type value);
      code_type len;
      len = '0;
      for (int i = 0; i < CountW; i++) begin
         if (value[i]) begin
            len = CodeW'(i + 1);
         end
      end
      return len;
   endfunction

   // count rounded up to a power of two, zero when empty
   function automatic count_type round_up_pow2(input count_type count);
      count_type pow2;
      if (count == '0) begin
         pow2 = '0;
      end else begin
         pow2 = count_type'(1) << bit_len(count - count_type'(1));
      end
      return pow2;
   endfunction

   // lzw minimum code size, raised to two, zero when empty
   function automatic code_type min_code(input count_type count);
      code_type len;
      code_type code;
      len = bit_len(count - count_type'(1));
      if (count == '0) begin
         code = '0;
      end else if (len < MinCode) begin
         code = MinCode;
      end else begin
         code = len;
      end
      return code;
   endfunction

endpackage

// File: src/rpi_req_if.sv
`timescale 1ns / 1ps
// pixel request channel: valid/ready handshake with rgb and end-of-image flag
// depends on rpi_pkg
interface rpi_req_if;
   logic                      valid;
   logic                      ready;
   logic [rpi_pkg::ColorW-1:0] red;
   logic [rpi_pkg::ColorW-1:0] green;
   logic [rpi_pkg::ColorW-1:0] blue;
   logic                      last_pixel;

   modport source (output valid, red, green, blue, last_pixel, input ready);
   modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

// File: src/rpi_rsp_if.sv
`timescale 1ns / 1ps
// palette index response channel: valid/ready handshake with index and table info
// depends on rpi_pkg
interface rpi_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rpi_pkg::IndexW-1:0] pixel_index;
   logic                       overflow;
   logic [rpi_pkg::CountW-1:0] color_count;
   logic [rpi_pkg::CountW-1:0] table_size;
   logic [rpi_pkg::CodeW-1:0]  min_code_size;

   modport source (output valid, pixel_index, overflow, color_count, table_size,
                   min_code_size, input ready);
   modport sink (input valid, pixel_index, overflow, color_count, table_size,
                 min_code_size, output ready);
endinterface

// File: src/rgb_palette_indexer_top.sv
`timescale 1ns / 1ps
// Exact-match palette indexer. A pixel accepted on req_bus walks a row of PALETTE_DEPTH
// compare cells, one cell per clock unless rsp_bus stalls; each cell holds one palette
// color, and the first empty cell a missing color reaches takes it. One pixel is accepted
// every clock unless rsp_bus stalls; the response register follows the cell row, and a
// stalled rsp_bus freezes the whole row. The pixel marked last empties each cell as it
// passes, so the next image starts with an empty palette and no clearing pass.
// depends on rpi_pkg, rpi_req_if, rpi_rsp_if, rpi_cell, rpi_tail
module rgb_palette_indexer_top #(
   parameter int PALETTE_DEPTH = rpi_pkg::PaletteDepth
) (
   input logic       clock,
   input logic       reset,
   rpi_req_if.sink   req_bus,
   rpi_rsp_if.source rsp_bus
);
   import rpi_pkg::*;

   beat_type chain_beat [PALETTE_DEPTH+1];
   logic     advance;

   // incoming beat enters the first cell with an empty search state
   always_comb begin
      chain_beat[0].valid       = req_bus.valid;
      chain_beat[0].rgb         = {req_bus.red, req_bus.green, req_bus.blue};
      chain_beat[0].last_pixel  = req_bus.last_pixel;
      chain_beat[0].found       = 1'b0;
      chain_beat[0].pixel_index = '0;
      chain_beat[0].color_count = '0;
   end

   assign req_bus.ready = advance;

   // row of palette cells
   for (genvar gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_cell
      rpi_cell #(
         .CELL_INDEX(gi)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .beat_i (chain_beat[gi]),
         .beat_o (chain_beat[gi+1])
      );
   end

   // response stage
   rpi_tail #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_tail (
      .clock  (clock),
      .reset  (reset),
      .beat_i (chain_beat[PALETTE_DEPTH]),
      .advance(advance),
      .rsp_bus(rsp_bus)
   );

endmodule

// File: src/rpi_cell.sv
`timescale 1ns / 1ps
// one palette cell: holds one color entry, compares the passing beat, appends on a miss
// depends on rpi_pkg
module rpi_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  rpi_pkg::beat_type beat_i,
   output rpi_pkg::beat_type beat_o
);
   import rpi_pkg::*;

   localparam index_type CellIdx   = IndexW'(CELL_INDEX);
   localparam count_type CellCount = CountW'(CELL_INDEX + 1);

   rgb_type  entry_ff, entry_in;
   logic     used_ff, used_in;
   beat_type beat_ff, beat_in;
   logic     hit;
   logic     append;

   // compare and append decision
   always_comb begin
      hit     = used_ff && (entry_ff == beat_i.rgb);
      append  = beat_i.valid && !beat_i.found && !used_ff;
      beat_in = beat_i;
      if (beat_i.valid) begin
         if (!beat_i.found && (hit || append)) begin
            beat_in.found       = 1'b1;
            beat_in.pixel_index = CellIdx;
         end
         if (used_ff || append) begin
            beat_in.color_count = CellCount;
         end
      end
   end

   // entry occupancy, cleared once the last pixel of an image has passed
   always_comb begin
      used_in  = used_ff;
      entry_in = entry_ff;
      if (beat_i.valid) begin
         used_in = beat_i.last_pixel ? 1'b0 : (used_ff || append);
      end
      if (append) begin
         entry_in = beat_i.rgb;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= 1'b0;
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         used_ff <= used_in;
         beat_ff <= beat_in;
      end
   end

   // color payload
   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

// File: src/rpi_tail.sv
`timescale 1ns / 1ps
// end of the cell row: sticky overflow, table size, code size and the response register
// depends on rpi_pkg, rpi_rsp_if, assert_macros.svh
`include "assert_macros.svh"
module rpi_tail #(
   parameter int PALETTE_DEPTH = rpi_pkg::PaletteDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  rpi_pkg::beat_type beat_i,
   output logic              advance,
   rpi_rsp_if.source         rsp_bus
);
   import rpi_pkg::*;

   localparam count_type FullCount = CountW'(PALETTE_DEPTH);

   logic      rsp_valid_ff;
   index_type index_ff, index_in;
   logic      overflow_ff, overflow_in;
   count_type count_ff;
   count_type size_ff, size_in;
   code_type  code_ff, code_in;
   logic      sticky_ff, sticky_in;

   // chain moves whenever the response register is free or being taken
   assign advance = !rsp_valid_ff || rsp_bus.ready;

   // result fields for the beat leaving the last cell
   always_comb begin
      overflow_in = sticky_ff || !beat_i.found;
      index_in    = beat_i.found ? beat_i.pixel_index : '0;
      size_in     = round_up_pow2(beat_i.color_count);
      code_in     = min_code(beat_i.color_count);
      sticky_in   = beat_i.last_pixel ? 1'b0 : overflow_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sticky_ff    <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= beat_i.valid;
         if (beat_i.valid) begin
            sticky_ff <= sticky_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (advance) begin
         index_ff    <= index_in;
         overflow_ff <= overflow_in;
         count_ff    <= beat_i.color_count;
         size_ff     <= size_in;
         code_ff     <= code_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pixel_index   = index_ff;
   assign rsp_bus.overflow      = overflow_ff;
   assign rsp_bus.color_count   = count_ff;
   assign rsp_bus.table_size    = size_ff;
   assign rsp_bus.min_code_size = code_ff;

   // overflow only ever shows with a full palette
   `RPI_ASSERT_NOW(a_overflow_full, clock, reset, rsp_valid_ff && overflow_ff,
      count_ff == FullCount, "overflow reported with palette not full")

   // an index always points inside the stored colors
   `RPI_ASSERT_NOW(a_index_in_range, clock, reset, rsp_valid_ff,
      (CountW'(index_ff) < count_ff), "pixel index beyond color count")

   // a sticky overflow keeps showing on the next beat of the same image
   `RPI_ASSERT_NEXT(a_sticky_holds, clock, reset,
      advance && beat_i.valid && !beat_i.last_pixel && overflow_in,
      sticky_ff, "overflow flag dropped inside an image")

endmodule

// File: tb/tb_rgb_palette_indexer_top.sv
`timescale 1ns / 1ps
// self-checking bench for rgb_palette_indexer_top: random and directed pixel images,
// exact palette prediction in a scoreboard class, random stalls on both channels
// depends on rpi_pkg, rpi_req_if, rpi_rsp_if and the indexer rtl
module tb_rgb_palette_indexer_top;
   import rpi_pkg::*;

   localparam int RandomPixels = 1450;
   localparam int LongHold     = 700;
   localparam int SettleCycles = 300;

   typedef enum int {IMG_POOL, IMG_NOISE, IMG_FILL} image_kind_e;

   typedef struct {
      index_type pixel_index;
      logic      overflow;
      count_type color_count;
      count_type table_size;
      code_type  min_code_size;
   } pixel_result_type;

   // palette tracker: predicts one result per accepted pixel and checks results in order
   class palette_scoreboard;
      rgb_type          colors[PaletteDepth];
      int unsigned      stored;
      bit               overflowed;
      pixel_result_type pending[$];
      int unsigned      errors;
      int unsigned      results;
      int unsigned      overflows;
      int unsigned      full_hits;
      int unsigned      images;

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      function void note_pixel(rgb_type color, logic last);
         pixel_result_type res;
         int hit;
         int pow2;
         hit = -1;
         // associative search over the stored colors only
         for (int i = 0; i < stored; i++) begin
            if (colors[i] == color) begin
               hit = i;
               break;
            end
         end
         if (hit >= 0) begin
            res.pixel_index = index_type'(hit);
            if (stored == PaletteDepth) begin
               full_hits++;
            end
         end else if (stored < PaletteDepth) begin
            colors[stored] = color;
            res.pixel_index = index_type'(stored);
            stored++;
         end else begin
            overflowed = 1'b1;
            res.pixel_index = '0;
            overflows++;
         end
         // table size and code size follow the count after this pixel
         pow2 = 1;
         while (pow2 < stored) begin
            pow2 = pow2 << 1;
         end
         res.overflow = overflowed;
         res.color_count = count_type'(stored);
         res.table_size = count_type'(pow2);
         res.min_code_size = (pow2 <= 2) ? code_type'(2) : code_type'($clog2(pow2));
         pending.push_back(res);
         // end of image empties the palette
         if (last) begin
            stored = 0;
            overflowed = 1'b0;
            images++;
         end
      endfunction

      task check_field(string name, logic [8:0] got, logic [8:0] want);
         if (got !== want) begin
            report($sformatf("result %0d %s got %0d expected %0d", results, name, got, want));
         end
      endtask

      task check_result(index_type idx, logic ovf, count_type count,
                        count_type tsize, code_type code);
         pixel_result_type want;
         results++;
         if (pending.size() == 0) begin
            report($sformatf("result %0d arrived with no pixel pending", results));
            return;
         end
         want = pending.pop_front();
         check_field("pixel_index", 9'(idx), 9'(want.pixel_index));
         check_field("overflow", 9'(ovf), 9'(want.overflow));
         check_field("color_count", count, want.color_count);
         check_field("table_size", tsize, want.table_size);
         check_field("min_code_size", 9'(code), 9'(want.min_code_size));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   rpi_req_if req_bus ();
   rpi_rsp_if rsp_bus ();

   rgb_palette_indexer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   palette_scoreboard sb = new();

   int unsigned pixels_sent;
   bit          sender_calm;
   bit          rsp_long_hold;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // beat monitor: check the result first, then note the new pixel
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.pixel_index, rsp_bus.overflow, rsp_bus.color_count,
                            rsp_bus.table_size, rsp_bus.min_code_size);
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_pixel({req_bus.red, req_bus.green, req_bus.blue}, req_bus.last_pixel);
         end
      end
   end

   // idle length: mostly none or short, a few long
   function automatic int pick_gap(bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // offer one pixel after a random gap, return once it is accepted
   task automatic send_pixel(input rgb_type color, input logic last);
      int gap;
      gap = pick_gap(sender_calm || rsp_long_hold);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.red        <= color[23:16];
      req_bus.green      <= color[15:8];
      req_bus.blue       <= color[7:0];
      req_bus.last_pixel <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pixels_sent++;
   endtask

   // stop offering until every pending result has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // image built from a few repeated colors
   task automatic send_pool_image();
      rgb_type pool[8];
      int      pool_n;
      int      len;
      pool_n = $urandom_range(1, 8);
      len = $urandom_range(1, 40);
      for (int i = 0; i < pool_n; i++) begin
         pool[i] = 24'($urandom);
      end
      for (int i = 0; i < len; i++) begin
         send_pixel(pool[$urandom_range(0, pool_n - 1)], i == len - 1);
      end
   endtask

   // random colors with stray end-of-image marks
   task automatic send_noise_image();
      int len;
      len = $urandom_range(1, 60);
      for (int i = 0; i < len; i++) begin
         send_pixel(24'($urandom), (i == len - 1) || ($urandom_range(0, 15) == 0));
      end
   endtask

   // fills all palette entries, then either only known colors or a mix of known and overflowing ones
   task automatic send_fill_image();
      rgb_type seen[$];
      rgb_type color;
      bit      only_known;
      int      tail;
      only_known = ($urandom_range(0, 2) == 0);
      tail = $urandom_range(20, 60);
      for (int i = 0; i < PaletteDepth; i++) begin
         if (seen.size() > 0 && $urandom_range(0, 3) == 0) begin
            send_pixel(seen[$urandom_range(0, seen.size() - 1)], 1'b0);
         end
         // low byte keeps the fill colors distinct
         color = {16'($urandom), 8'(i)};
         seen.push_back(color);
         send_pixel(color, 1'b0);
      end
      for (int i = 0; i < tail; i++) begin
         if (only_known || $urandom_range(0, 1) == 0) begin
            color = seen[$urandom_range(0, PaletteDepth - 1)];
         end else begin
            color = 24'($urandom);
         end
         send_pixel(color, i == tail - 1);
      end
   endtask

   // result channel back-pressure, with one long hold once traffic is going
   initial begin : rsp_drive
      int hold;
      int calm_left;
      bit calm;
      bit long_done;
      hold = 0;
      calm_left = 0;
      calm = 1'b0;
      long_done = 1'b0;
      rsp_long_hold = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_done && sb.results >= 300) begin
            long_done = 1'b1;
            rsp_long_hold = 1'b1;
            hold = LongHold;
         end
         if (calm_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(50, 300);
         end
         calm_left--;
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_long_hold = 1'b0;
            if (!calm && $urandom_range(0, 2) == 0) begin
               hold = pick_gap(1'b0);
            end
         end
         @(posedge clock);
      end
   end

   // reset, directed pixels, random images, drain and verdict
   initial begin : stimulus
      image_kind_e kind;
      int unsigned base;
      int unsigned fill_images;
      fill_images = 0;
      pixels_sent = 0;
      sender_calm = 1'b0;
      req_bus.valid      <= 1'b0;
      req_bus.red        <= '0;
      req_bus.green      <= '0;
      req_bus.blue       <= '0;
      req_bus.last_pixel <= 1'b0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, hits, growth of the table and code size, short images
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFF0000, 1'b0);
      send_pixel(24'h00FF00, 1'b0);
      send_pixel(24'h0000FF, 1'b0);
      send_pixel(24'hAA55AA, 1'b0);
      send_pixel(24'h55AA55, 1'b0);
      send_pixel(24'h808080, 1'b0);
      send_pixel(24'hFFFFFF, 1'b1);
      send_pixel(24'hFFFFFF, 1'b1);
      send_pixel(24'h0000FF, 1'b0);
      send_pixel(24'h0000FF, 1'b1);
      send_pixel(24'h000001, 1'b0);
      send_pixel(24'h800000, 1'b0);
      send_pixel(24'h000001, 1'b1);
      wait_for_drain();

      // random images until the pixel budget is spent
      base = pixels_sent;
      for (int img = 0; pixels_sent - base < RandomPixels; img++) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         if (img % 7 == 2) begin
            kind = IMG_FILL;
         end else if ($urandom_range(0, 9) < 7) begin
            kind = IMG_POOL;
         end else begin
            kind = IMG_NOISE;
         end
         case (kind)
            IMG_FILL: begin
               send_fill_image();
               fill_images++;
            end
            IMG_POOL: send_pool_image();
            default: send_noise_image();
         endcase
         if (!rsp_long_hold && $urandom_range(0, 7) == 0) begin
            wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (SettleCycles) @(posedge clock);
      if (sb.pending.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      end

      $display("covered %0d pixels over %0d images, %0d full-palette fills", pixels_sent,
               sb.images, fill_images);
      $display("%0d results checked, %0d overflow pixels, %0d hits on a full palette",
               sb.results, sb.overflows, sb.full_hits);
      if (sb.errors == 0) begin
         $display("** rgb_palette_indexer_top: PASSED **");
      end else begin
         $display("** rgb_palette_indexer_top: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #4000000;
      $display("timeout with %0d pixels sent and %0d results pending", pixels_sent,
               sb.pending.size());
      $display("** rgb_palette_indexer_top: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/rpi_pkg.sv
src/rpi_req_if.sv
src/rpi_rsp_if.sv
src/rpi_cell.sv
src/rpi_tail.sv
src/rgb_palette_indexer_top.sv
tb/tb_rgb_palette_indexer_top.sv
